[rtl/tvg_pkg.sv]
// ----------------------------------------------------------------------------
// tvg_pkg
// Shared types, command and result codes for the turtle vector generator.
// ----------------------------------------------------------------------------
package tvg_pkg;

   localparam int DEF_COORD_BITS         = 16;
   localparam int DEF_TRIG_FRACTION_BITS = 16;
   localparam int CMD_QUEUE_DEPTH        = 2;
   localparam int RSP_QUEUE_DEPTH        = 2;

   localparam int RESET_X = 512;
   localparam int RESET_Y = 384;

   localparam logic [9:0] DEG_FULL = 10'd360;

   // operation codes on the request channel
   localparam logic [3:0] OP_FWD      = 4'd0;
   localparam logic [3:0] OP_BACK     = 4'd1;
   localparam logic [3:0] OP_RIGHT    = 4'd2;
   localparam logic [3:0] OP_LEFT     = 4'd3;
   localparam logic [3:0] OP_PEN_UP   = 4'd4;
   localparam logic [3:0] OP_PEN_DOWN = 4'd5;
   localparam logic [3:0] OP_HOME     = 4'd6;
   localparam logic [3:0] OP_CLEAR    = 4'd7;
   localparam logic [3:0] OP_SETXY    = 4'd8;
   localparam logic [3:0] OP_SETH     = 4'd9;
   localparam logic [3:0] OP_COLOR    = 4'd10;
   localparam logic [3:0] OP_WIDTH    = 4'd11;

   // result action codes
   localparam logic [2:0] ACT_NONE  = 3'd0;
   localparam logic [2:0] ACT_LINE  = 3'd1;
   localparam logic [2:0] ACT_CLEAR = 3'd2;
   localparam logic [2:0] ACT_COLOR = 3'd3;
   localparam logic [2:0] ACT_WIDTH = 3'd4;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOME_X = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOME_Y = 1'd1;

   typedef enum logic [3:0] {
      CMD_MOVE,
      CMD_RIGHT,
      CMD_LEFT,
      CMD_PEN_UP,
      CMD_PEN_DOWN,
      CMD_HOME,
      CMD_CLEAR,
      CMD_SETXY,
      CMD_SETH,
      CMD_COLOR,
      CMD_WIDTH,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic signed [16:0] travel;
      logic [8:0]         amod;
      logic signed [15:0] set_x;
      logic signed [15:0] set_y;
      logic [23:0]        color;
      logic [14:0]        width;
   } cmd_type;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [15:0] x_start;
      logic signed [15:0] y_start;
      logic signed [15:0] x_end;
      logic signed [15:0] y_end;
      logic [23:0]        color;
      logic [14:0]        width;
      logic [8:0]         heading;
      logic               pen_is_down;
      logic               last;
   } rsp_type;

endpackage

[rtl/tvg_queue.sv]
// ----------------------------------------------------------------------------
// tvg_queue
// Small synchronous FIFO with full and empty flags.
// ----------------------------------------------------------------------------
module tvg_queue import tvg_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = CMD_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/tvg_front.sv]
// ----------------------------------------------------------------------------
// tvg_front
// Command decode: classifies the operation, reduces angles modulo 360 and
// packs the fields the back end needs into one command word.
// ----------------------------------------------------------------------------
module tvg_front import tvg_pkg::*; (
   input  logic               req_push,
   input  logic [3:0]         req_operation,
   input  logic signed [15:0] req_amount,
   input  logic signed [15:0] req_y_value,
   input  logic [7:0]         req_red,
   input  logic [7:0]         req_green,
   input  logic [7:0]         req_blue,
   input  logic               cmdq_full,
   output logic               cmdq_push,
   output cmd_type            cmd
);

   // (high byte * 256) mod 360, high byte taken as signed
   logic [8:0] hi_mod [256];

   for (genvar i = 0; i < 256; i++) begin : g_hi_mod
      localparam int HV = (i < 128) ? i : i - 256;
      localparam int MV = ((HV * 256) % 360 + 360) % 360;
      assign hi_mod[i] = 9'(MV);
   end

   logic [9:0]         amod_sum;
   logic [8:0]         amod;
   logic signed [16:0] amount_w;
   logic               amount_pos;

   assign amod_sum   = {1'b0, hi_mod[req_amount[15:8]]} + {2'b00, req_amount[7:0]};
   assign amod       = (amod_sum >= DEG_FULL) ? 9'(amod_sum - DEG_FULL) : amod_sum[8:0];
   assign amount_w   = 17'(req_amount);
   assign amount_pos = !req_amount[15] && (req_amount != '0);
   assign cmdq_push  = req_push && !cmdq_full;

   always_comb begin
      cmd        = '0;
      cmd.kind   = CMD_NOP;
      cmd.travel = (req_operation == OP_BACK) ? -amount_w : amount_w;
      cmd.amod   = amod;
      cmd.set_x  = req_amount;
      cmd.set_y  = req_y_value;
      case (req_operation)
         OP_FWD,
         OP_BACK:     cmd.kind = CMD_MOVE;
         OP_RIGHT:    cmd.kind = CMD_RIGHT;
         OP_LEFT:     cmd.kind = CMD_LEFT;
         OP_PEN_UP:   cmd.kind = CMD_PEN_UP;
         OP_PEN_DOWN: cmd.kind = CMD_PEN_DOWN;
         OP_HOME:     cmd.kind = CMD_HOME;
         OP_CLEAR:    cmd.kind = CMD_CLEAR;
         OP_SETXY:    cmd.kind = CMD_SETXY;
         OP_SETH:     cmd.kind = CMD_SETH;
         OP_COLOR: begin
            cmd.kind  = CMD_COLOR;
            cmd.color = {req_blue, req_green, req_red};
         end
         OP_WIDTH: begin
            cmd.kind  = CMD_WIDTH;
            cmd.width = amount_pos ? req_amount[14:0] : 15'd1;
         end
         default:     cmd.kind = CMD_NOP;
      endcase
   end

endmodule

[rtl/tvg_back.sv]
// ----------------------------------------------------------------------------
// tvg_back
// Execution: heading, pen and trig products in the first stage, position
// update and result generation in the commit stage.
// ----------------------------------------------------------------------------
module tvg_back import tvg_pkg::*; #(
   parameter int COORD_BITS         = DEF_COORD_BITS,
   parameter int TRIG_FRACTION_BITS = DEF_TRIG_FRACTION_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmdq_empty,
   input  cmd_type                   cmd,
   output logic                      cmdq_pop,
   input  logic                      rspq_full,
   output logic                      rspq_push,
   output rsp_type                   rsp,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic signed [15:0]        csr_data
);

   localparam int F  = TRIG_FRACTION_BITS;
   localparam int TW = F + 1;
   localparam int PW = F + 19;
   localparam int PB = (COORD_BITS > 11) ? COORD_BITS : 11;
   localparam int SW = ((PB > 16) ? PB : 16) + 2;
   localparam int SINE_ENTRIES = 91;
   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic [9:0]  DEG_QUARTER = 10'd90;

   localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
   localparam logic signed [PW-1:0] RND    = PW'((64'sd1 <<< F) - 64'sd1);

   localparam logic [1:0] POS_KEEP = 2'd0;
   localparam logic [1:0] POS_STEP = 2'd1;
   localparam logic [1:0] POS_SET  = 2'd2;
   localparam logic [1:0] POS_HOME = 2'd3;

   localparam logic PHASE_FIRST  = 1'b0;
   localparam logic PHASE_SECOND = 1'b1;

   typedef struct packed {
      logic       neg;
      logic [6:0] idx;
   } trig_sel_type;

   typedef struct packed {
      logic [2:0]         act;
      logic               dual;
      logic [1:0]         pos_kind;
      logic signed [PW-1:0] prod_x;
      logic signed [PW-1:0] prod_y;
      logic signed [15:0] set_x;
      logic signed [15:0] set_y;
      logic [23:0]        color;
      logic [14:0]        width;
      logic [8:0]         head_old;
      logic [8:0]         head_new;
      logic               pen_old;
      logic               pen_new;
   } exec_rec_type;

   // (a*b) >> 60 on 64-bit words
   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] ah, al, bh, bl, lo, mid, hi, t, low64, high;
      ah    = a >> 32;
      al    = {32'd0, a[31:0]};
      bh    = b >> 32;
      bl    = {32'd0, b[31:0]};
      lo    = al * bl;
      mid   = ah * bl + al * bh;
      hi    = ah * bh;
      t     = (lo >> 32) + {32'd0, mid[31:0]};
      low64 = {t[31:0], lo[31:0]};
      high  = hi + (mid >> 32) + (t >> 32);
      return (high << 4) | (low64 >> 60);
   endfunction

   // sine of a whole degree by Taylor series, rounded half up
   function automatic logic [63:0] quarter_sine(input int deg, input int frac);
      logic [63:0] step, x, x2, term, sum;
      step = PI_Q60 / 64'd180;
      x    = step * 64'(deg);
      x2   = mul_q60(x, x);
      term = x;
      sum  = x;
      for (int k = 1; k < 20; k++) begin
         term = mul_q60(term, x2) / 64'((2 * k) * (2 * k + 1));
         if ((k % 2) == 1) sum = sum - term;
         else              sum = sum + term;
      end
      return (sum + (64'd1 << (59 - frac))) >> (60 - frac);
   endfunction

   function automatic trig_sel_type sine_select(input logic [8:0] h);
      trig_sel_type s;
      if (h <= 9'd90) begin
         s.neg = 1'b0;
         s.idx = h[6:0];
      end else if (h <= 9'd180) begin
         s.neg = 1'b0;
         s.idx = 7'(9'd180 - h);
      end else if (h <= 9'd270) begin
         s.neg = 1'b1;
         s.idx = 7'(h - 9'd180);
      end else begin
         s.neg = 1'b1;
         s.idx = 7'(9'd360 - h);
      end
      return s;
   endfunction

   function automatic logic signed [PB-1:0] sat_coord(input logic signed [SW-1:0] v);
      if (v > SAT_HI) return PB'(SAT_HI);
      if (v < SAT_LO) return PB'(SAT_LO);
      return PB'(v);
   endfunction

   logic [TW-1:0] sine_rom [SINE_ENTRIES];

   for (genvar d = 0; d < SINE_ENTRIES; d++) begin : g_sine
      localparam logic [TW-1:0] SV = TW'(quarter_sine(d, F));
      assign sine_rom[d] = SV;
   end

   // ---------------- state ----------------
   logic signed [15:0]   home_x_ff, home_x_in;
   logic signed [15:0]   home_y_ff, home_y_in;
   logic [8:0]           heading_ff, heading_in;
   logic                 pen_ff, pen_in;
   logic signed [PB-1:0] pos_x_ff, pos_x_in;
   logic signed [PB-1:0] pos_y_ff, pos_y_in;
   logic                 b_valid_ff, b_valid_in;
   exec_rec_type         b_rec_ff, b_rec_in;
   logic                 phase_ff, phase_in;

   // ---------------- execute stage ----------------
   logic [9:0]           hc_sum, r_sum, l_diff;
   logic [8:0]           head_cos, r_head, l_head;
   trig_sel_type         sin_sel, cos_sel;
   logic signed [F+1:0]  sin_mag, cos_mag, sin_v, cos_v;
   logic signed [PW-1:0] prod_x, prod_y;
   logic [2:0]           line_act;
   exec_rec_type         rec;

   assign hc_sum   = {1'b0, heading_ff} + DEG_QUARTER;
   assign head_cos = (hc_sum >= DEG_FULL) ? 9'(hc_sum - DEG_FULL) : hc_sum[8:0];
   assign sin_sel  = sine_select(heading_ff);
   assign cos_sel  = sine_select(head_cos);
   assign sin_mag  = $signed({1'b0, sine_rom[sin_sel.idx]});
   assign cos_mag  = $signed({1'b0, sine_rom[cos_sel.idx]});
   assign sin_v    = sin_sel.neg ? -sin_mag : sin_mag;
   assign cos_v    = cos_sel.neg ? -cos_mag : cos_mag;
   assign prod_x   = $signed(cmd.travel) * cos_v;
   assign prod_y   = $signed(cmd.travel) * sin_v;

   assign r_sum    = {1'b0, heading_ff} + {1'b0, cmd.amod};
   assign r_head   = (r_sum >= DEG_FULL) ? 9'(r_sum - DEG_FULL) : r_sum[8:0];
   assign l_diff   = {1'b0, heading_ff} - {1'b0, cmd.amod};
   assign l_head   = l_diff[9] ? 9'(l_diff + DEG_FULL) : l_diff[8:0];
   assign line_act = pen_ff ? ACT_LINE : ACT_NONE;

   always_comb begin
      rec          = '0;
      rec.act      = ACT_NONE;
      rec.pos_kind = POS_KEEP;
      rec.prod_x   = prod_x;
      rec.prod_y   = prod_y;
      rec.set_x    = cmd.set_x;
      rec.set_y    = cmd.set_y;
      rec.color    = cmd.color;
      rec.width    = cmd.width;
      rec.head_old = heading_ff;
      rec.head_new = heading_ff;
      rec.pen_old  = pen_ff;
      rec.pen_new  = pen_ff;
      case (cmd.kind)
         CMD_MOVE: begin
            rec.act      = line_act;
            rec.pos_kind = POS_STEP;
         end
         CMD_RIGHT:    rec.head_new = r_head;
         CMD_LEFT:     rec.head_new = l_head;
         CMD_PEN_UP:   rec.pen_new  = 1'b0;
         CMD_PEN_DOWN: rec.pen_new  = 1'b1;
         CMD_HOME: begin
            rec.act      = line_act;
            rec.pos_kind = POS_HOME;
            rec.head_new = '0;
         end
         CMD_CLEAR: begin
            rec.dual     = 1'b1;
            rec.act      = line_act;
            rec.pos_kind = POS_HOME;
            rec.head_new = '0;
            rec.pen_new  = 1'b1;
         end
         CMD_SETXY: begin
            rec.act      = line_act;
            rec.pos_kind = POS_SET;
         end
         CMD_SETH:     rec.head_new = cmd.amod;
         CMD_COLOR:    rec.act      = ACT_COLOR;
         CMD_WIDTH:    rec.act      = ACT_WIDTH;
         default:      rec.act      = ACT_NONE;
      endcase
   end

   // ---------------- commit stage ----------------
   logic                 b_first, b_done;
   logic signed [PW-1:0] px_b, py_b;
   logic signed [SW-1:0] step_x, step_y, pos_x_w, pos_y_w;
   logic signed [PB-1:0] new_x, new_y;
   logic signed [SW-1:0] new_x_w, new_y_w;

   assign b_first   = b_rec_ff.dual && (phase_ff == PHASE_FIRST);
   assign rspq_push = b_valid_ff && !rspq_full;
   assign b_done    = rspq_push && !b_first;
   assign cmdq_pop  = !cmdq_empty && (!b_valid_ff || b_done);

   // truncate toward zero: bias negative products before the shift
   assign px_b    = b_rec_ff.prod_x + (b_rec_ff.prod_x[PW-1] ? RND : '0);
   assign py_b    = b_rec_ff.prod_y + (b_rec_ff.prod_y[PW-1] ? RND : '0);
   assign step_x  = SW'($signed(px_b[PW-1:F]));
   assign step_y  = SW'($signed(py_b[PW-1:F]));
   assign pos_x_w = SW'(pos_x_ff);
   assign pos_y_w = SW'(pos_y_ff);

   always_comb begin
      case (b_rec_ff.pos_kind)
         POS_STEP: begin
            new_x = sat_coord(pos_x_w + step_x);
            new_y = sat_coord(pos_y_w + step_y);
         end
         POS_SET: begin
            new_x = sat_coord(SW'($signed(b_rec_ff.set_x)));
            new_y = sat_coord(SW'($signed(b_rec_ff.set_y)));
         end
         POS_HOME: begin
            new_x = sat_coord(SW'(home_x_ff));
            new_y = sat_coord(SW'(home_y_ff));
         end
         default: begin
            new_x = pos_x_ff;
            new_y = pos_y_ff;
         end
      endcase
   end

   assign new_x_w = SW'(new_x);
   assign new_y_w = SW'(new_y);

   always_comb begin
      rsp             = '0;
      rsp.x_start     = pos_x_w[15:0];
      rsp.y_start     = pos_y_w[15:0];
      rsp.color       = b_rec_ff.color;
      rsp.width       = b_rec_ff.width;
      if (b_first) begin
         rsp.action      = ACT_CLEAR;
         rsp.x_end       = pos_x_w[15:0];
         rsp.y_end       = pos_y_w[15:0];
         rsp.heading     = b_rec_ff.head_old;
         rsp.pen_is_down = b_rec_ff.pen_old;
         rsp.last        = 1'b0;
      end else begin
         rsp.action      = b_rec_ff.act;
         rsp.x_end       = new_x_w[15:0];
         rsp.y_end       = new_y_w[15:0];
         rsp.heading     = b_rec_ff.head_new;
         rsp.pen_is_down = b_rec_ff.pen_new;
         rsp.last        = 1'b1;
      end
   end

   // ---------------- next state ----------------
   always_comb begin
      home_x_in = home_x_ff;
      home_y_in = home_y_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_HOME_X: home_x_in = csr_data;
            CSR_HOME_Y: home_y_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      heading_in = cmdq_pop ? rec.head_new : heading_ff;
      pen_in     = cmdq_pop ? rec.pen_new : pen_ff;
      b_rec_in   = cmdq_pop ? rec : b_rec_ff;
      b_valid_in = cmdq_pop ? 1'b1 : (b_done ? 1'b0 : b_valid_ff);
      pos_x_in   = b_done ? new_x : pos_x_ff;
      pos_y_in   = b_done ? new_y : pos_y_ff;
      phase_in   = phase_ff;
      if (b_done) begin
         phase_in = PHASE_FIRST;
      end else if (rspq_push && b_first) begin
         phase_in = PHASE_SECOND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         home_x_ff  <= 16'(RESET_X);
         home_y_ff  <= 16'(RESET_Y);
         heading_ff <= '0;
         pen_ff     <= 1'b1;
         pos_x_ff   <= PB'(RESET_X);
         pos_y_ff   <= PB'(RESET_Y);
         b_valid_ff <= 1'b0;
         phase_ff   <= PHASE_FIRST;
      end else begin
         home_x_ff  <= home_x_in;
         home_y_ff  <= home_y_in;
         heading_ff <= heading_in;
         pen_ff     <= pen_in;
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         b_valid_ff <= b_valid_in;
         phase_ff   <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      b_rec_ff <= b_rec_in;
   end

endmodule

[rtl/turtle_vector_generator.sv]
// ----------------------------------------------------------------------------
// turtle_vector_generator
// Turtle-graphics engine: turns turtle commands into line, clear, colour and
// width results.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue input: drive req_* and req_push; a command is
//   taken on a clock edge with req_push high and req_full low.
//   Result side is a queue output: while rsp_empty is low the oldest result
//   sits on rsp_*; it is taken on an edge with rsp_pop high.
//   csr_write loads home_x (index 0) or home_y (index 1) from csr_data;
//   write them only while no command is in flight.
//   Each command passes the command queue, the commit-stage register and
//   the result queue. Throughput: one command per cycle while the result
//   queue has room; a clear holds the commit stage for both of its results,
//   as the commit stage writes one result per cycle into the result queue.
//   A two-entry command queue sits between decode and execution and a
//   two-entry result queue behind the commit stage, so a stalled receiver
//   first fills the result queue, then the pipeline, then the command queue
//   before req_full rises; nothing is dropped.
//   Synchronous reset empties both queues and returns the turtle to
//   (512, 384), heading 0, pen down, with home registers at 512 and 384.
// ----------------------------------------------------------------------------
module turtle_vector_generator import tvg_pkg::*; #(
   parameter int COORD_BITS         = DEF_COORD_BITS,
   parameter int TRIG_FRACTION_BITS = DEF_TRIG_FRACTION_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [3:0]                req_operation,
   input  logic signed [15:0]        req_amount,
   input  logic signed [15:0]        req_y_value,
   input  logic [7:0]                req_red,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_blue,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [2:0]                rsp_action,
   output logic signed [15:0]        rsp_x_start,
   output logic signed [15:0]        rsp_y_start,
   output logic signed [15:0]        rsp_x_end,
   output logic signed [15:0]        rsp_y_end,
   output logic [23:0]               rsp_color,
   output logic [14:0]               rsp_width,
   output logic [8:0]                rsp_heading,
   output logic                      rsp_pen_is_down,
   output logic                      rsp_last,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic signed [15:0]        csr_data
);

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   logic    cmdq_push, cmdq_full, cmdq_pop, cmdq_empty;
   cmd_type cmd_front, cmd_back;
   logic    rspq_push, rspq_full;
   rsp_type rsp_back, rsp_out;

   tvg_front u_front (
      .req_push      (req_push),
      .req_operation (req_operation),
      .req_amount    (req_amount),
      .req_y_value   (req_y_value),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .cmdq_full     (cmdq_full),
      .cmdq_push     (cmdq_push),
      .cmd           (cmd_front)
   );

   tvg_queue #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmdq_push),
      .push_data (cmd_front),
      .full      (cmdq_full),
      .pop       (cmdq_pop),
      .pop_data  (cmd_back),
      .empty     (cmdq_empty)
   );

   tvg_back #(
      .COORD_BITS         (COORD_BITS),
      .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmdq_empty (cmdq_empty),
      .cmd        (cmd_back),
      .cmdq_pop   (cmdq_pop),
      .rspq_full  (rspq_full),
      .rspq_push  (rspq_push),
      .rsp        (rsp_back),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   tvg_queue #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rspq_push),
      .push_data (rsp_back),
      .full      (rspq_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_out),
      .empty     (rsp_empty)
   );

   assign req_full        = cmdq_full;
   assign rsp_action      = rsp_out.action;
   assign rsp_x_start     = rsp_out.x_start;
   assign rsp_y_start     = rsp_out.y_start;
   assign rsp_x_end       = rsp_out.x_end;
   assign rsp_y_end       = rsp_out.y_end;
   assign rsp_color       = rsp_out.color;
   assign rsp_width       = rsp_out.width;
   assign rsp_heading     = rsp_out.heading;
   assign rsp_pen_is_down = rsp_out.pen_is_down;
   assign rsp_last        = rsp_out.last;

endmodule

[rtl/tvg_checker.sv]
// ----------------------------------------------------------------------------
// tvg_checker
// Port-level checks on the result channel of the turtle vector generator.
// ----------------------------------------------------------------------------
module tvg_checker import tvg_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic [2:0]         rsp_action,
   input logic signed [15:0] rsp_x_start,
   input logic signed [15:0] rsp_y_start,
   input logic signed [15:0] rsp_x_end,
   input logic signed [15:0] rsp_y_end,
   input logic [23:0]        rsp_color,
   input logic [8:0]         rsp_heading,
   input logic               rsp_last
);

   // queue is empty straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // a waiting beat stays put until taken
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_action) && $stable(rsp_x_end) && $stable(rsp_last)))
      else $error("waiting result changed before pop");

   // only the clear beat is followed by a second result, and it leaves position alone
   a_split_is_clear: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_last) |->
         (rsp_action == ACT_CLEAR && rsp_x_end == rsp_x_start && rsp_y_end == rsp_y_start))
      else $error("non-final result that is not a clear");

   a_fields_sane: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |->
         ({1'b0, rsp_heading} < DEG_FULL && (rsp_action == ACT_COLOR || rsp_color == 24'd0)))
      else $error("heading out of range or stray colour");

endmodule

bind turtle_vector_generator tvg_checker u_tvg_checker (.*);

[sim/turtle_vector_generator_tb.sv]
// ----------------------------------------------------------------------------
// turtle_vector_generator_tb
// Self-checking bench for the turtle vector generator. Commands are pushed
// from a pending queue with random gaps, results are popped with random
// stalls and compared field by field against a cycle-free turtle predictor.
// Home registers are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module turtle_vector_generator_tb import tvg_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CYCLE_LIMIT     = 400000;
   localparam int          RANDOM_PER_PASS = 130;
   localparam logic [3:0]  OP_UNUSED_FIRST = 4'd12;
   localparam logic [3:0]  OP_UNUSED_LAST  = 4'd15;
   localparam int          FRAC_BITS       = DEF_TRIG_FRACTION_BITS;
   localparam longint unsigned PI_Q60      = 64'h3243F6A8885A308D;

   typedef struct packed {
      logic [3:0]         op;
      logic signed [15:0] amount;
      logic signed [15:0] y_value;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
   } turtle_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_push = 1'b0;
   logic               req_full;
   logic [3:0]         req_operation = '0;
   logic signed [15:0] req_amount = '0;
   logic signed [15:0] req_y_value = '0;
   logic [7:0]         req_red = '0;
   logic [7:0]         req_green = '0;
   logic [7:0]         req_blue = '0;

   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [2:0]         rsp_action;
   logic signed [15:0] rsp_x_start;
   logic signed [15:0] rsp_y_start;
   logic signed [15:0] rsp_x_end;
   logic signed [15:0] rsp_y_end;
   logic [23:0]        rsp_color;
   logic [14:0]        rsp_width;
   logic [8:0]         rsp_heading;
   logic               rsp_pen_is_down;
   logic               rsp_last;

   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_HOME_X;
   logic signed [15:0]        csr_data = '0;

   turtle_vector_generator dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_operation   (req_operation),
      .req_amount      (req_amount),
      .req_y_value     (req_y_value),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_action      (rsp_action),
      .rsp_x_start     (rsp_x_start),
      .rsp_y_start     (rsp_y_start),
      .rsp_x_end       (rsp_x_end),
      .rsp_y_end       (rsp_y_end),
      .rsp_color       (rsp_color),
      .rsp_width       (rsp_width),
      .rsp_heading     (rsp_heading),
      .rsp_pen_is_down (rsp_pen_is_down),
      .rsp_last        (rsp_last),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // turtle predictor
   // ------------------------------------------------------------------
   longint unsigned quarter_sine [0:90];
   longint          turtle_x, turtle_y, turtle_heading;
   logic            turtle_pen;
   longint          home_x_reg, home_y_reg;

   turtle_cmd_type pending_cmds [$];
   rsp_type        expected_rsp [$];

   bit     offer_open  = 1'b0;
   bit     calm        = 1'b0;
   int     hold_left   = 0;
   int     error_count = 0;
   int     cmds_taken  = 0;
   int     rsps_seen   = 0;
   int     lines_seen  = 0;
   int     clears_seen = 0;
   int     stalls_seen = 0;
   longint cycle_count = 0;

   // (a*b) >> 60, low 64 bits
   function automatic longint unsigned q60_mul(longint unsigned a, longint unsigned b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   function automatic void build_sine_table();
      longint unsigned step, x, x2, term, sum;
      step = PI_Q60 / 180;
      for (int d = 0; d <= 90; d++) begin
         x    = step * longint'(d);
         x2   = q60_mul(x, x);
         term = x;
         sum  = x;
         for (longint unsigned k = 1; k < 20 && term != 0; k++) begin
            term = q60_mul(term, x2) / ((2 * k) * (2 * k + 1));
            if (k[0]) sum = sum - term;
            else      sum = sum + term;
         end
         quarter_sine[d] = (sum + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
      end
   endfunction

   function automatic longint sine_deg(longint h);
      h = h % 360;
      if (h < 0) h += 360;
      if (h <= 90)  return longint'(quarter_sine[h]);
      if (h <= 180) return longint'(quarter_sine[180 - h]);
      if (h <= 270) return -longint'(quarter_sine[h - 180]);
      return -longint'(quarter_sine[360 - h]);
   endfunction

   // product truncated toward zero
   function automatic longint trig_step(longint move_len, longint trig);
      longint p;
      p = move_len * trig;
      if (p < 0) return -((-p) >> FRAC_BITS);
      return p >> FRAC_BITS;
   endfunction

   function automatic longint clamp_coord(longint v);
      if (v > 32767)  return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint wrap_deg(longint a);
      a = a % 360;
      if (a < 0) a += 360;
      return a;
   endfunction

   function automatic rsp_type make_rsp(logic [2:0] act, longint xs, longint ys,
                                        logic [23:0] col, logic [14:0] wid, logic fin);
      rsp_type r;
      r.action      = act;
      r.x_start     = xs[15:0];
      r.y_start     = ys[15:0];
      r.x_end       = turtle_x[15:0];
      r.y_end       = turtle_y[15:0];
      r.color       = col;
      r.width       = wid;
      r.heading     = turtle_heading[8:0];
      r.pen_is_down = turtle_pen;
      r.last        = fin;
      return r;
   endfunction

   task automatic turtle_step(input turtle_cmd_type c);
      longint     amt, yv, move_len, xs, ys;
      logic [2:0] line_act;
      amt      = longint'($signed(c.amount));
      yv       = longint'($signed(c.y_value));
      xs       = turtle_x;
      ys       = turtle_y;
      line_act = turtle_pen ? ACT_LINE : ACT_NONE;
      case (c.op)
         OP_FWD, OP_BACK: begin
            move_len = (c.op == OP_FWD) ? amt : -amt;
            turtle_x = clamp_coord(turtle_x
                                   + trig_step(move_len, sine_deg(turtle_heading + 90)));
            turtle_y = clamp_coord(turtle_y + trig_step(move_len, sine_deg(turtle_heading)));
            expected_rsp.push_back(make_rsp(line_act, xs, ys, '0, '0, 1'b1));
         end
         OP_RIGHT: begin
            turtle_heading = wrap_deg(turtle_heading + amt);
            expected_rsp.push_back(make_rsp(ACT_NONE, xs, ys, '0, '0, 1'b1));
         end
         OP_LEFT: begin
            turtle_heading = wrap_deg(turtle_heading - amt);
            expected_rsp.push_back(make_rsp(ACT_NONE, xs, ys, '0, '0, 1'b1));
         end
         OP_PEN_UP: begin
            turtle_pen = 1'b0;
            expected_rsp.push_back(make_rsp(ACT_NONE, xs, ys, '0, '0, 1'b1));
         end
         OP_PEN_DOWN: begin
            turtle_pen = 1'b1;
            expected_rsp.push_back(make_rsp(ACT_NONE, xs, ys, '0, '0, 1'b1));
         end
         OP_HOME: begin
            turtle_x       = clamp_coord(home_x_reg);
            turtle_y       = clamp_coord(home_y_reg);
            turtle_heading = 0;
            expected_rsp.push_back(make_rsp(line_act, xs, ys, '0, '0, 1'b1));
         end
         OP_CLEAR: begin
            expected_rsp.push_back(make_rsp(ACT_CLEAR, xs, ys, '0, '0, 1'b0));
            turtle_x       = clamp_coord(home_x_reg);
            turtle_y       = clamp_coord(home_y_reg);
            turtle_heading = 0;
            turtle_pen     = 1'b1;
            expected_rsp.push_back(make_rsp(line_act, xs, ys, '0, '0, 1'b1));
         end
         OP_SETXY: begin
            turtle_x = clamp_coord(amt);
            turtle_y = clamp_coord(yv);
            expected_rsp.push_back(make_rsp(line_act, xs, ys, '0, '0, 1'b1));
         end
         OP_SETH: begin
            turtle_heading = wrap_deg(amt);
            expected_rsp.push_back(make_rsp(ACT_NONE, xs, ys, '0, '0, 1'b1));
         end
         OP_COLOR:
            expected_rsp.push_back(make_rsp(ACT_COLOR, xs, ys, {c.blue, c.green, c.red},
                                            '0, 1'b1));
         OP_WIDTH:
            expected_rsp.push_back(make_rsp(ACT_WIDTH, xs, ys, '0,
                                            (amt > 0) ? amt[14:0] : 15'd1, 1'b1));
         default:
            expected_rsp.push_back(make_rsp(ACT_NONE, xs, ys, '0, '0, 1'b1));
      endcase
   endtask

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic turtle_cmd_type mk_cmd(logic [3:0] op, logic signed [15:0] amt,
                                             logic signed [15:0] yv = '0,
                                             logic [7:0] r = '0, logic [7:0] g = '0,
                                             logic [7:0] b = '0);
      turtle_cmd_type c;
      c.op      = op;
      c.amount  = amt;
      c.y_value = yv;
      c.red     = r;
      c.green   = g;
      c.blue    = b;
      return c;
   endfunction

   function automatic logic signed [15:0] random_amount();
      logic signed [15:0] a;
      case ($urandom_range(3))
         0:       a = 16'($urandom);
         1:       a = $signed(16'($urandom_range(400))) - 16'sd200;
         2:       a = $signed(16'(90 * $urandom_range(8))) - 16'sd360
                      + $signed(16'($urandom_range(2))) - 16'sd1;
         default: a = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      endcase
      return a;
   endfunction

   function automatic turtle_cmd_type random_cmd();
      turtle_cmd_type c;
      int             pick;
      pick      = $urandom_range(99);
      c.amount  = random_amount();
      c.y_value = 16'($urandom);
      c.red     = 8'($urandom);
      c.green   = 8'($urandom);
      c.blue    = 8'($urandom);
      if      (pick < 18) c.op = OP_FWD;
      else if (pick < 28) c.op = OP_BACK;
      else if (pick < 38) c.op = OP_RIGHT;
      else if (pick < 46) c.op = OP_LEFT;
      else if (pick < 53) c.op = OP_SETH;
      else if (pick < 59) c.op = OP_PEN_UP;
      else if (pick < 65) c.op = OP_PEN_DOWN;
      else if (pick < 70) c.op = OP_HOME;
      else if (pick < 76) c.op = OP_CLEAR;
      else if (pick < 84) c.op = OP_SETXY;
      else if (pick < 90) c.op = OP_COLOR;
      else if (pick < 96) c.op = OP_WIDTH;
      else                c.op = 4'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      return c;
   endfunction

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || expected_rsp.size() != 0 || offer_open)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_home(logic signed [15:0] hx, logic signed [15:0] hy);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_HOME_X;
      csr_data  <= hx;
      @(negedge clock);
      csr_index <= CSR_HOME_Y;
      csr_data  <= hy;
      @(negedge clock);
      csr_write <= 1'b0;
      home_x_reg = longint'(hx);
      home_y_reg = longint'(hy);
   endtask

   task automatic random_pass(logic signed [15:0] hx, logic signed [15:0] hy);
      write_home(hx, hy);
      repeat (RANDOM_PER_PASS) pending_cmds.push_back(random_cmd());
   endtask

   // ------------------------------------------------------------------
   // request driver: one offer held until taken
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!offer_open) begin
         if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
            req_operation <= pending_cmds[0].op;
            req_amount    <= pending_cmds[0].amount;
            req_y_value   <= pending_cmds[0].y_value;
            req_red       <= pending_cmds[0].red;
            req_green     <= pending_cmds[0].green;
            req_blue      <= pending_cmds[0].blue;
            req_push      <= 1'b1;
            offer_open    = 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // request beat taken: predict
   always @(posedge clock) begin
      if (!reset && req_push) begin
         if (req_full) begin
            stalls_seen++;
         end else begin
            turtle_step(pending_cmds.pop_front());
            cmds_taken++;
            offer_open = 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // result side: random stalls, long hold-off on request
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_pop   <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_pop <= calm || ($urandom_range(99) >= 25);
      end
   end

   task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         error_count++;
         $display("%0t: result %0d field %s expected %0d actual %0d",
                  $realtime, rsps_seen, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_rsp.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result beat, expected none, actual action %0d",
                     $realtime, rsp_action);
         end else begin
            e = expected_rsp.pop_front();
            check_field("action", e.action, rsp_action);
            check_field("x_start", 16'(e.x_start), 16'(rsp_x_start));
            check_field("y_start", 16'(e.y_start), 16'(rsp_y_start));
            check_field("x_end", 16'(e.x_end), 16'(rsp_x_end));
            check_field("y_end", 16'(e.y_end), 16'(rsp_y_end));
            check_field("color", e.color, rsp_color);
            check_field("width", e.width, rsp_width);
            check_field("heading", e.heading, rsp_heading);
            check_field("pen_is_down", e.pen_is_down, rsp_pen_is_down);
            check_field("last", e.last, rsp_last);
            if (e.action == ACT_LINE)  lines_seen++;
            if (e.action == ACT_CLEAR) clears_seen++;
         end
         rsps_seen++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d commands pending and %0d results outstanding",
                  $realtime, pending_cmds.size(), expected_rsp.size());
         $display("turtle_vector_generator_tb NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      build_sine_table();
      turtle_x       = RESET_X;
      turtle_y       = RESET_Y;
      turtle_heading = 0;
      turtle_pen     = 1'b1;
      home_x_reg     = RESET_X;
      home_y_reg     = RESET_Y;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed part on reset home values
      pending_cmds.push_back(mk_cmd(OP_FWD, 16'sd0));
      pending_cmds.push_back(mk_cmd(OP_FWD, 16'sh7FFF));
      pending_cmds.push_back(mk_cmd(OP_BACK, 16'sh8000));
      pending_cmds.push_back(mk_cmd(OP_RIGHT, 16'sd45));
      pending_cmds.push_back(mk_cmd(OP_FWD, 16'sd300));
      pending_cmds.push_back(mk_cmd(OP_RIGHT, 16'sh8000));
      pending_cmds.push_back(mk_cmd(OP_LEFT, 16'sh7FFF));
      pending_cmds.push_back(mk_cmd(OP_LEFT, -16'sd1));
      pending_cmds.push_back(mk_cmd(OP_SETH, 16'sd359));
      pending_cmds.push_back(mk_cmd(OP_SETH, 16'sh8000));
      pending_cmds.push_back(mk_cmd(OP_SETH, 16'sd90));
      pending_cmds.push_back(mk_cmd(OP_BACK, 16'sd1000));
      pending_cmds.push_back(mk_cmd(OP_PEN_UP, 16'sd0));
      pending_cmds.push_back(mk_cmd(OP_FWD, 16'sd50));
      pending_cmds.push_back(mk_cmd(OP_HOME, 16'sd0));
      pending_cmds.push_back(mk_cmd(OP_SETXY, 16'sh8000, 16'sh7FFF));
      pending_cmds.push_back(mk_cmd(OP_CLEAR, 16'sd0));
      pending_cmds.push_back(mk_cmd(OP_SETXY, 16'sh7FFF, 16'sh8000));
      pending_cmds.push_back(mk_cmd(OP_SETH, 16'sd180));
      pending_cmds.push_back(mk_cmd(OP_FWD, 16'sh7FFF));
      pending_cmds.push_back(mk_cmd(OP_COLOR, 16'sd0, 16'sd0, 8'hFF, 8'h00, 8'hAA));
      pending_cmds.push_back(mk_cmd(OP_COLOR, 16'sd0, 16'sd0, 8'h00, 8'hFF, 8'h55));
      pending_cmds.push_back(mk_cmd(OP_WIDTH, 16'sd0));
      pending_cmds.push_back(mk_cmd(OP_WIDTH, 16'sh8000));
      pending_cmds.push_back(mk_cmd(OP_WIDTH, 16'sh7FFF));
      pending_cmds.push_back(mk_cmd(OP_UNUSED_FIRST, 16'sh7FFF));
      pending_cmds.push_back(mk_cmd(OP_UNUSED_LAST, 16'sh8000));
      pending_cmds.push_back(mk_cmd(OP_CLEAR, 16'sd0));
      wait_drained();

      // receiver holds off while the sender keeps offering
      write_home(16'sh8000, 16'sh7FFF);
      hold_left = 300;
      repeat (RANDOM_PER_PASS) pending_cmds.push_back(random_cmd());
      wait_drained();

      // back-to-back beats, no idling on either side
      calm = 1'b1;
      random_pass(16'sh7FFF, 16'sh8000);
      wait_drained();
      calm = 1'b0;

      random_pass(16'sd0, 16'sd0);
      wait_drained();
      random_pass(16'($urandom), 16'($urandom));
      wait_drained();
      random_pass(16'(RESET_X), 16'(RESET_Y));
      wait_drained();

      $display("covered %0d commands, %0d results (%0d lines, %0d clears)",
               cmds_taken, rsps_seen, lines_seen, clears_seen);
      $display("request side saw %0d stalled cycles; home registers set to 5 values",
               stalls_seen);
      if (error_count == 0) begin
         $display("turtle_vector_generator_tb OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("turtle_vector_generator_tb NOT OK");
      end
      $finish;
   end

endmodule
